// ===== hdl/cim_row_bitwise_alu_unit_defines.svh =====
// Assertion macros for the checker of the row word unit.
`ifndef CIM_ROW_BITWISE_ALU_UNIT_DEFINES_SVH
`define CIM_ROW_BITWISE_ALU_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define CRA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define CRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cra_pkg.sv =====
package cra_pkg;

  localparam int WORD_BITS  = 64;
  localparam int MASK_BITS  = 8;
  localparam int WORD_BYTES = 8;

  // lanes actually present in the row word
  localparam logic [MASK_BITS-1:0] LANE_MASK =
    MASK_BITS'((16'd1 << WORD_BYTES) - 16'd1);

  typedef enum logic [2:0] {
    OP_AND  = 3'd0,
    OP_OR   = 3'd1,
    OP_XOR  = 3'd2,
    OP_COPY = 3'd3,
    OP_NOTC = 3'd4
  } opcode_t;

  // control from the top level to the fold unit
  typedef struct packed {
    logic step;   // input stage word moves on this cycle
    logic last;   // word closes its run
  } fold_ctl_t;

  // byte mask to a bit mask over the whole word
  function automatic logic [WORD_BITS-1:0] expand_mask(input logic [MASK_BITS-1:0] m);
    logic [WORD_BITS-1:0] w;
    w = '0;
    for (int i = 0; i < MASK_BITS; i++) begin
      w[8*i +: 8] = {8{m[i]}};
    end
    return w;
  endfunction

  function automatic logic is_fold(input opcode_t op);
    return (op == OP_AND) || (op == OP_OR) || (op == OP_XOR);
  endfunction

endpackage

// ===== hdl/cra_fold_unit.sv =====
module cra_fold_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  cra_pkg::fold_ctl_t            ctl,
  input  cra_pkg::opcode_t              op,
  input  logic [cra_pkg::WORD_BITS-1:0] word,
  output logic [cra_pkg::WORD_BITS-1:0] fold_word
);
  import cra_pkg::*;

  logic [WORD_BITS-1:0] acc;
  logic                 run;
  logic [WORD_BITS-1:0] base;

  // a new run starts from the identity of its first opcode
  always_comb begin
    if (run) begin
      base = acc;
    end else if (op == OP_AND) begin
      base = '1;
    end else begin
      base = '0;
    end
    case (op)
      OP_AND:  fold_word = base & word;
      OP_OR:   fold_word = base | word;
      OP_XOR:  fold_word = base ^ word;
      default: fold_word = base;
    endcase
  end

  // accumulator advances with each fold word that leaves the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      run <= 1'b0;
    end else if (ctl.step && is_fold(op)) begin
      if (ctl.last) begin
        acc <= '0;
        run <= 1'b0;
      end else begin
        acc <= fold_word;
        run <= 1'b1;
      end
    end
  end

endmodule

// ===== hdl/cra_byte_ops.sv =====
module cra_byte_ops (
  input  cra_pkg::opcode_t              op,
  input  logic [cra_pkg::WORD_BITS-1:0] word,
  input  logic [cra_pkg::WORD_BITS-1:0] wmask,
  input  logic [7:0]                    rotate_amount,
  input  logic                          always_invert,
  input  logic                          invert_if_zero,
  output logic [cra_pkg::WORD_BITS-1:0] byte_word
);
  import cra_pkg::*;

  logic [WORD_BITS-1:0]   src;
  logic [5:0]             amt;
  logic [2*WORD_BITS-1:0] dbl;
  logic [WORD_BITS-1:0]   rot_word;
  logic [WORD_BITS-1:0]   inv_word;

  // copy: masked source, left rotate only for 1..63
  assign src      = word & wmask;
  assign amt      = (rotate_amount[7:6] == 2'b00) ? rotate_amount[5:0] : 6'd0;
  assign dbl      = {src, src} << amt;
  assign rot_word = dbl[2*WORD_BITS-1:WORD_BITS];

  // conditional invert, per byte
  always_comb begin
    if (always_invert) begin
      inv_word = ~word;
    end else begin
      for (int i = 0; i < WORD_BITS / 8; i++) begin
        inv_word[8*i +: 8] = {8{(word[8*i +: 8] == 8'h00) == invert_if_zero}};
      end
    end
  end

  always_comb begin
    case (op)
      OP_COPY: byte_word = rot_word;
      default: byte_word = inv_word;
    endcase
  end

endmodule

// ===== hdl/cim_row_bitwise_alu_unit.sv =====
// Channel  | Dir | tdata (lowest bit up)                               | tuser  | tlast
// s_axis   | in  | operand_word, write_mask, rotate_amount,            | opcode | last_row
//          |     | always_invert, invert_if_zero, 6 zero bits          |        |
// m_axis   | out | result_word, byte_write_enable                      | -      | -
//
// One word per cycle while m_axis is not stalled: an input register, one pass
// of byte logic and the fold accumulator, then the result register.
// The fold accumulator is updated when a fold word leaves the input register,
// so back-to-back fold words chain with no bubble.
// rst clears the valid flags, the accumulator and the run flag.
// A stalled m_axis holds its word; words that give no result still drain.
module cim_row_bitwise_alu_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operand_word[63:0], write_mask[71:64], rotate_amount[79:72],
  // always_invert[80], invert_if_zero[81], zero[87:82]
  input  logic [87:0] s_axis_tdata,
  // opcode[2:0]
  input  logic [2:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // result_word[63:0], byte_write_enable[71:64]
  output logic [71:0] m_axis_tdata
);
  import cra_pkg::*;

  // input register
  logic                 s1_valid;
  opcode_t              s1_op;
  logic [WORD_BITS-1:0] s1_word;
  logic [MASK_BITS-1:0] s1_mask;
  logic [7:0]           s1_rot;
  logic                 s1_always;
  logic                 s1_ifz;
  logic                 s1_last;

  // result register
  logic                 out_valid;
  logic [WORD_BITS-1:0] out_word;
  logic [MASK_BITS-1:0] out_mask;

  logic                 s_take;
  logic                 s1_go;
  logic                 produce;
  logic                 out_free;
  logic [WORD_BITS-1:0] wmask;
  logic [WORD_BITS-1:0] fold_word;
  logic [WORD_BITS-1:0] byte_word;
  logic [WORD_BITS-1:0] result_next;
  fold_ctl_t            fold_ctl;

  assign wmask = expand_mask(s1_mask);

  // which words give a result
  always_comb begin
    unique case (s1_op) inside
      OP_AND, OP_OR, OP_XOR: produce = s1_last;
      OP_COPY, OP_NOTC:      produce = 1'b1;
      default:               produce = 1'b0;
    endcase
  end

  // handshake between the two registers
  assign out_free      = !out_valid || m_axis_tready;
  assign s1_go         = s1_valid && (!produce || out_free);
  assign s_axis_tready = !s1_valid || s1_go;
  assign s_take        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_take) begin
      s1_op     <= opcode_t'(s_axis_tuser);
      s1_word   <= s_axis_tdata[63:0];
      s1_mask   <= s_axis_tdata[71:64] & LANE_MASK;
      s1_rot    <= s_axis_tdata[79:72];
      s1_always <= s_axis_tdata[80];
      s1_ifz    <= s_axis_tdata[81];
      s1_last   <= s_axis_tlast;
    end
  end

  assign fold_ctl.step = s1_go;
  assign fold_ctl.last = s1_last;

  cra_fold_unit u_fold (
    .clk       (clk),
    .rst       (rst),
    .ctl       (fold_ctl),
    .op        (s1_op),
    .word      (s1_word),
    .fold_word (fold_word)
  );

  cra_byte_ops u_bytes (
    .op             (s1_op),
    .word           (s1_word),
    .wmask          (wmask),
    .rotate_amount  (s1_rot),
    .always_invert  (s1_always),
    .invert_if_zero (s1_ifz),
    .byte_word      (byte_word)
  );

  assign result_next = (is_fold(s1_op) ? fold_word : byte_word) & wmask;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && produce) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && produce) begin
      out_word <= result_next;
      out_mask <= s1_mask;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_mask, out_word};

endmodule

// ===== hdl/cra_checker.sv =====
`include "cim_row_bitwise_alu_unit_defines.svh"

module cra_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);
  import cra_pkg::*;

  logic [WORD_BITS-1:0] out_wmask;

  assign out_wmask = expand_mask(m_axis_tdata[71:64]);

  // a stalled result word holds
  `CRA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

  // bytes not written are driven to zero
  `CRA_ASSERT_NOW(a_masked_zero, m_axis_tvalid,
    (m_axis_tdata[63:0] & ~out_wmask) == 64'd0, "disabled result byte not zero")

  // write enables only on lanes that exist
  `CRA_ASSERT_NOW(a_lanes, m_axis_tvalid,
    (m_axis_tdata[71:64] & ~LANE_MASK) == 8'd0, "write enable beyond word lanes")

  // with the result side free the input never stalls
  `CRA_ASSERT_NOW(a_ready, !m_axis_tvalid || m_axis_tready,
    s_axis_tready, "input stalled while the result side was free")

endmodule

bind cim_row_bitwise_alu_unit cra_checker u_cra_checker (.*);
